// File: rtl/first_free_slot_allocator_with_expiry_core_defines.svh
// Assertion helpers used by the allocator core.
`ifndef FIRST_FREE_SLOT_ALLOCATOR_WITH_EXPIRY_CORE_DEFINES_SVH
`define FIRST_FREE_SLOT_ALLOCATOR_WITH_EXPIRY_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define FFSA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFSA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ffsa_pkg.sv
`default_nettype none
package ffsa_pkg;

  localparam int unsigned TIME_FIELD_W = 16;
  localparam int unsigned SLOT_NUM_W   = 5;
  localparam int unsigned CFG_W        = 5;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned CFG_ADDR_W   = 3;

  // register index, taken from paddr[2]
  localparam logic REG_SLOTS_IN_USE = 1'b0;
  localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SWEEP  = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  // verdict of the slot compare unit
  typedef struct packed {
    logic expire;
    logic free;
  } cmp_res_t;

endpackage
`default_nettype wire

// File: rtl/ffsa_if.sv
`default_nettype none
interface ffsa_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [ffsa_pkg::TIME_FIELD_W-1:0]    start_time;
  logic [ffsa_pkg::TIME_FIELD_W-1:0]    end_time;
  modport source (output valid, start_time, end_time, input ready);
  modport sink   (input valid, start_time, end_time, output ready);
endinterface

interface ffsa_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 granted;
  logic [ffsa_pkg::SLOT_NUM_W-1:0]      slot_number;
  modport source (output valid, granted, slot_number, input ready);
  modport sink   (input valid, granted, slot_number, output ready);
endinterface
`default_nettype wire

// File: rtl/first_free_slot_allocator_with_expiry_core.sv
// Channel  | Dir | Handshake          | Payload
// ---------+-----+--------------------+---------------------------------------
// in_ch    | in  | valid/ready        | start_time[15:0], end_time[15:0]
// out_ch   | out | valid/ready        | granted, slot_number[4:0]
// cfg_*    | in  | APB, pready tied 1 | reg 0 @ 0x0: slots_in_use[4:0]
//
// A request is accepted, then swept over the end-time RAM (one read port, one
// slot per cycle, registered read data) and then committed in the grant state,
// which waits while the output register holds a result that is not taken.
// in_ch.ready is high only while the sequencer is idle; a held result in the
// output register does not block the next accept, only the next grant.
// Reset (rst_n, synchronous) frees every slot and sets slots_in_use to 16.
`default_nettype none
`include "first_free_slot_allocator_with_expiry_core_defines.svh"
module first_free_slot_allocator_with_expiry_core #(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  ffsa_in_if.sink                                  in_ch,
  ffsa_out_if.source                               out_ch,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [ffsa_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [ffsa_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic      [ffsa_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                     cfg_pready
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned LIM_W = (IDX_W + 1 > ffsa_pkg::CFG_W) ? IDX_W + 1
                                                                : ffsa_pkg::CFG_W;
  localparam int unsigned EXT_W = TIME_BITS + ffsa_pkg::TIME_FIELD_W;

  // ---------------- config register ----------------
  logic [ffsa_pkg::CFG_W-1:0] slots_in_use_r;
  logic                       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_in_use_r <= ffsa_pkg::SLOTS_IN_USE_RST;
    end else if (cfg_wr && (cfg_paddr[2] == ffsa_pkg::REG_SLOTS_IN_USE)) begin
      slots_in_use_r <= cfg_pwdata[ffsa_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == ffsa_pkg::REG_SLOTS_IN_USE) begin
      cfg_prdata = ffsa_pkg::CFG_DATA_W'(slots_in_use_r);
    end
  end

  // ---------------- request times ----------------
  // Times are kept at TIME_BITS; bits above that are dropped, missing ones zero.
  logic [EXT_W-1:0]     start_ext, end_ext;
  logic [TIME_BITS-1:0] start_r, finish_r;

  assign start_ext = EXT_W'(in_ch.start_time);
  assign end_ext   = EXT_W'(in_ch.end_time);

  // ---------------- sequencer ----------------
  ffsa_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;      // next slot to read
  logic             chk_vld_r;           // RAM data for chk_idx_r is out
  logic [IDX_W-1:0] chk_idx_r;
  logic             found_r, found_nxt;  // a free slot within the limit seen
  logic [IDX_W-1:0] pick_r, pick_nxt;
  logic [SLOTS-1:0] busy_r, busy_nxt;
  logic             in_acc, issue, load;

  logic                  out_vld_r, out_grant_r;
  logic [ffsa_pkg::SLOT_NUM_W-1:0] out_num_r;
  logic [LIM_W-1:0]      num_sum;

  logic [TIME_BITS-1:0]  ram_rdata;
  ffsa_pkg::cmp_res_t    cmp_res;

  assign in_ch.ready = (state_r == ffsa_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  // issue a read every sweep cycle until the counter passes the last slot
  assign issue       = (state_r == ffsa_pkg::ST_SWEEP) && (cnt_r != CNT_W'(SLOTS));
  // grant cycle: commit only when the output register has room
  assign load        = (state_r == ffsa_pkg::ST_FINISH) && (!out_vld_r || out_ch.ready);

  ffsa_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (SLOTS)
  ) u_end_ram (
    .clk   (clk),
    .we    (load && found_r),
    .waddr (pick_r),
    .wdata (finish_r),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // the one compare unit, walked across the pool
  ffsa_cmp #(
    .TIME_BITS (TIME_BITS),
    .LIM_W     (LIM_W)
  ) u_cmp (
    .busy       (busy_r[chk_idx_r]),
    .end_time   (ram_rdata),
    .start_time (start_r),
    .idx        (LIM_W'(chk_idx_r)),
    .limit      (LIM_W'(slots_in_use_r)),
    .res        (cmp_res)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    found_nxt = found_r;
    pick_nxt  = pick_r;
    busy_nxt  = busy_r;

    // expiry and first-free pick for the slot whose end time just came out
    if (chk_vld_r) begin
      if (cmp_res.expire) begin
        busy_nxt[chk_idx_r] = 1'b0;
      end
      if (cmp_res.free && !found_r) begin
        found_nxt = 1'b1;
        pick_nxt  = chk_idx_r;
      end
    end

    case (state_r)
      ffsa_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ffsa_pkg::ST_SWEEP;
          cnt_nxt   = '0;
          found_nxt = 1'b0;
        end
      end
      ffsa_pkg::ST_SWEEP: begin
        if (issue) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          // last slot is checked this cycle
          state_nxt = ffsa_pkg::ST_FINISH;
        end
      end
      ffsa_pkg::ST_FINISH: begin
        if (load) begin
          state_nxt = ffsa_pkg::ST_IDLE;
          if (found_r) begin
            busy_nxt[pick_r] = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ffsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ffsa_pkg::ST_IDLE;
      cnt_r     <= '0;
      chk_vld_r <= 1'b0;
      found_r   <= 1'b0;
      busy_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      chk_vld_r <= issue;
      found_r   <= found_nxt;
      busy_r    <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pick_r    <= pick_nxt;
    chk_idx_r <= cnt_r[IDX_W-1:0];
    if (in_acc) begin
      start_r  <= start_ext[TIME_BITS-1:0];
      finish_r <= end_ext[TIME_BITS-1:0];
    end
  end

  // ---------------- result register ----------------
  assign num_sum = LIM_W'(pick_r) + LIM_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_grant_r <= found_r;
      out_num_r   <= found_r ? num_sum[ffsa_pkg::SLOT_NUM_W-1:0] : '0;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.granted     = out_grant_r;
  assign out_ch.slot_number = out_num_r;

  // ---------------- checks ----------------
  `FFSA_ASSERT_IMP(a_chk_in_sweep, chk_vld_r, state_r == ffsa_pkg::ST_SWEEP, "check outside sweep")
  `FFSA_ASSERT_NXT(a_grant_marks_busy, load && found_r, busy_r[$past(pick_r)], "granted slot not busy")
  `FFSA_ASSERT_NXT(a_accept_starts_sweep, in_acc, state_r == ffsa_pkg::ST_SWEEP && cnt_r == '0, "sweep did not start")
  `FFSA_ASSERT_IMP(a_fail_zero_num, out_vld_r && !out_grant_r, out_num_r == '0, "failed result carries a number")
  `FFSA_ASSERT_IMP(a_pick_in_limit, (state_r == ffsa_pkg::ST_FINISH) && found_r, LIM_W'(pick_r) < LIM_W'(slots_in_use_r), "pick beyond slot limit")

endmodule
`default_nettype wire

// File: rtl/ffsa_ram.sv
`default_nettype none
module ffsa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: rtl/ffsa_cmp.sv
`default_nettype none
// One slot per use: expiry test on the stored end time, then the free test
// against the slot limit.
module ffsa_cmp #(
  parameter int unsigned TIME_BITS = 16,
  parameter int unsigned LIM_W     = 5
) (
  input  wire logic                 busy,
  input  wire logic [TIME_BITS-1:0] end_time,
  input  wire logic [TIME_BITS-1:0] start_time,
  input  wire logic [LIM_W-1:0]     idx,
  input  wire logic [LIM_W-1:0]     limit,
  output ffsa_pkg::cmp_res_t        res
);

  always_comb begin
    res.expire = busy && (end_time <= start_time);
    res.free   = (!busy || res.expire) && (idx < limit);
  end

endmodule
`default_nettype wire
